/* rtl/rsi_pkg.sv */
// ----------------------------------------------------------------------------
// rsi_pkg
// shared widths, constants, types and helpers of the ray/sphere intersection
// ----------------------------------------------------------------------------
package rsi_pkg;

	localparam int FRAC_BITS = 16;
	localparam int DW        = 32;
	localparam int RAD_W     = 31;
	localparam int MIND_W    = 16;
	localparam int DIST_W    = 31;
	localparam int CFG_W     = 31;
	localparam int IDX_W     = 1;

	localparam logic [RAD_W-1:0]  RAD_RST  = RAD_W'(65536);
	localparam logic [MIND_W-1:0] MIND_RST = MIND_W'(66);

	typedef enum logic [IDX_W-1:0] {
		REG_RADIUS   = 1'b0,
		REG_MIN_DIST = 1'b1
	} reg_idx_t;

	localparam logic [DIST_W-1:0] T_MAX      = '1;
	localparam logic [DW-1:0]     NORM_ONE   = 32'h4000_0000;
	localparam int                NORM_SHIFT = 62;

	// square root unit: one result bit per stage
	localparam int SQ_RW    = 64;
	localparam int SQ_XW    = 2 * SQ_RW;
	localparam int SQRT_LAT = SQ_RW;

	// divider: one quotient bit per stage
	localparam int DIV_DW  = 64;
	localparam int DIV_QW  = 32;
	localparam int DIV_NW  = DIV_DW + DIV_QW;
	localparam int DIV_LAT = DIV_QW;

	// fourteen named stages plus the two root units and two divider rows
	localparam int PIPE_LAT = 14 + 2 * SQRT_LAT + 2 * DIV_LAT;

	typedef logic [2:0][DW-1:0] vec3_t;

	typedef struct packed {
		logic        azero;
		logic        dneg;
		logic        hpos;
		logic [63:0] hmag;
		logic [63:0] a;
		vec3_t       o;
		vec3_t       d;
	} side6_t;

	typedef struct packed {
		logic  nohit;
		logic  hpos;
		logic  vn;
		logic  vf;
		vec3_t o;
		vec3_t d;
	} side7_t;

	typedef struct packed {
		logic              hit;
		logic              szero;
		logic [DIST_W-1:0] t;
		vec3_t             p;
	} side12_t;

	function automatic logic [DW-1:0] abs32(input logic [DW-1:0] v);
		logic [DW-1:0] r;
		r = v[DW-1] ? DW'(-v) : v;
		return r;
	endfunction

endpackage

/* rtl/ray_sphere_intersection.sv */
// ----------------------------------------------------------------------------
// ray_sphere_intersection
// ray against a centred sphere in its local frame: distance, point, normal
// throughput: one ray per clock whenever busy is low, results never wait
// depth is set by two 64-stage square root units and two rows of 32-stage dividers
// reset: valid pipeline cleared, radius 1.0 and min distance 66 restored,
// busy is high during reset and the first clock after it
// ----------------------------------------------------------------------------
module ray_sphere_intersection (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic                          wr_en,
	input  logic [rsi_pkg::IDX_W-1:0]     wr_index,
	input  logic [rsi_pkg::CFG_W-1:0]     wr_data,
	input  logic signed [31:0]            origin_x,
	input  logic signed [31:0]            origin_y,
	input  logic signed [31:0]            origin_z,
	input  logic signed [31:0]            direction_x,
	input  logic signed [31:0]            direction_y,
	input  logic signed [31:0]            direction_z,
	output logic                          done,
	output logic                          is_hit,
	output logic [rsi_pkg::DIST_W-1:0]    hit_distance,
	output logic signed [31:0]            point_x,
	output logic signed [31:0]            point_y,
	output logic signed [31:0]            point_z,
	output logic signed [31:0]            normal_x,
	output logic signed [31:0]            normal_y,
	output logic signed [31:0]            normal_z
);
	import rsi_pkg::*;

	function automatic logic [DW-1:0] sat32(input logic signed [63:0] v);
		logic [DW-1:0] r;
		if (v > 64'sd2147483647)
			r = 32'h7FFF_FFFF;
		else if (v < -64'sd2147483648)
			r = 32'h8000_0000;
		else
			r = v[DW-1:0];
		return r;
	endfunction

	// ---------------- control and configuration ----------------
	logic                   busy_q;
	logic [PIPE_LAT-1:0]    vld_q;
	logic [RAD_W-1:0]       sphere_radius_q;
	logic [MIND_W-1:0]      min_distance_q;
	logic                   accept;

	assign accept = start & ~busy_q;
	assign busy   = busy_q;
	assign done   = vld_q[PIPE_LAT-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b1;
			vld_q  <= '0;
		end else begin
			busy_q <= 1'b0;
			vld_q  <= {vld_q[PIPE_LAT-2:0], accept};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sphere_radius_q <= RAD_RST;
			min_distance_q  <= MIND_RST;
		end else if (wr_en) begin
			case (wr_index)
				REG_RADIUS:   sphere_radius_q <= wr_data[RAD_W-1:0];
				REG_MIN_DIST: min_distance_q  <= wr_data[MIND_W-1:0];
				default: ;
			endcase
		end
	end

	// ---------------- s1: per-axis products ----------------
	vec3_t o_in, d_in;
	assign o_in = {origin_z, origin_y, origin_x};
	assign d_in = {direction_z, direction_y, direction_x};

	vec3_t              o_s1, d_s1;
	logic [63:0]        sqd_s1 [3];
	logic [63:0]        sqo_s1 [3];
	logic signed [63:0] pr_s1  [3];

	always_ff @(posedge clk) begin
		o_s1 <= o_in;
		d_s1 <= d_in;
		for (int i = 0; i < 3; i++) begin
			sqd_s1[i] <= abs32(d_in[i]) * abs32(d_in[i]);
			sqo_s1[i] <= abs32(o_in[i]) * abs32(o_in[i]);
			pr_s1[i]  <= $signed(d_in[i]) * $signed(o_in[i]);
		end
	end

	// ---------------- s2: dot products, r^2 ----------------
	vec3_t       o_s2, d_s2;
	logic [63:0] a_s2, oo_s2, hp_s2, hm_s2;
	logic [61:0] r2_s2;
	logic [63:0] a_c, oo_c, hp_c, hm_c;

	always_comb begin
		a_c  = '0;
		oo_c = '0;
		hp_c = '0;
		hm_c = '0;
		for (int i = 0; i < 3; i++) begin
			a_c  = a_c + sqd_s1[i];
			oo_c = oo_c + sqo_s1[i];
			if (pr_s1[i][63])
				hm_c = hm_c + 64'(-pr_s1[i]);
			else
				hp_c = hp_c + 64'(pr_s1[i]);
		end
	end

	always_ff @(posedge clk) begin
		o_s2  <= o_s1;
		d_s2  <= d_s1;
		a_s2  <= a_c;
		oo_s2 <= oo_c;
		hp_s2 <= hp_c;
		hm_s2 <= hm_c;
		r2_s2 <= sphere_radius_q * sphere_radius_q;
	end

	// ---------------- s3: signs and magnitudes of h and c ----------------
	vec3_t       o_s3, d_s3;
	logic [63:0] a_s3, hmag_s3, cmag_s3;
	logic        hpos_s3, cneg_s3, azero_s3;

	always_ff @(posedge clk) begin
		o_s3     <= o_s2;
		d_s3     <= d_s2;
		a_s3     <= a_s2;
		azero_s3 <= a_s2 == '0;
		hpos_s3  <= hp_s2 > hm_s2;
		hmag_s3  <= (hp_s2 >= hm_s2) ? hp_s2 - hm_s2 : hm_s2 - hp_s2;
		cneg_s3  <= oo_s2 < 64'(r2_s2);
		cmag_s3  <= (oo_s2 < 64'(r2_s2)) ? 64'(r2_s2) - oo_s2 : oo_s2 - 64'(r2_s2);
	end

	// ---------------- s4: 32x32 partial products of h*h and a*c ----------------
	vec3_t       o_s4, d_s4;
	logic [63:0] a_s4, hmag_s4;
	logic        hpos_s4, cneg_s4, azero_s4;
	logic [63:0] h00_s4, h01_s4, h11_s4;
	logic [63:0] ac00_s4, ac01_s4, ac10_s4, ac11_s4;

	always_ff @(posedge clk) begin
		o_s4     <= o_s3;
		d_s4     <= d_s3;
		a_s4     <= a_s3;
		hmag_s4  <= hmag_s3;
		hpos_s4  <= hpos_s3;
		cneg_s4  <= cneg_s3;
		azero_s4 <= azero_s3;
		h00_s4   <= hmag_s3[31:0] * hmag_s3[31:0];
		h01_s4   <= hmag_s3[31:0] * hmag_s3[63:32];
		h11_s4   <= hmag_s3[63:32] * hmag_s3[63:32];
		ac00_s4  <= a_s3[31:0] * cmag_s3[31:0];
		ac01_s4  <= a_s3[31:0] * cmag_s3[63:32];
		ac10_s4  <= a_s3[63:32] * cmag_s3[31:0];
		ac11_s4  <= a_s3[63:32] * cmag_s3[63:32];
	end

	// ---------------- s5: assemble h*h and a*c ----------------
	vec3_t        o_s5, d_s5;
	logic [63:0]  a_s5, hmag_s5;
	logic         hpos_s5, cneg_s5, azero_s5;
	logic [127:0] hh_s5, ac_s5;

	always_ff @(posedge clk) begin
		o_s5     <= o_s4;
		d_s5     <= d_s4;
		a_s5     <= a_s4;
		hmag_s5  <= hmag_s4;
		hpos_s5  <= hpos_s4;
		cneg_s5  <= cneg_s4;
		azero_s5 <= azero_s4;
		hh_s5    <= {h11_s4, 64'd0} + (128'(h01_s4) << 33) + 128'(h00_s4);
		ac_s5    <= {ac11_s4, 64'd0} + ((128'(ac01_s4) + 128'(ac10_s4)) << 32)
			+ 128'(ac00_s4);
	end

	// ---------------- s6: discriminant ----------------
	side6_t             side_s6;
	logic [SQ_XW-1:0]   disc_s6;

	always_ff @(posedge clk) begin
		side_s6.azero <= azero_s5;
		side_s6.dneg  <= ~cneg_s5 & (hh_s5 < ac_s5);
		side_s6.hpos  <= hpos_s5;
		side_s6.hmag  <= hmag_s5;
		side_s6.a     <= a_s5;
		side_s6.o     <= o_s5;
		side_s6.d     <= d_s5;
		disc_s6       <= cneg_s5 ? hh_s5 + ac_s5 : hh_s5 - ac_s5;
	end

	// ---------------- square root of the discriminant ----------------
	logic [SQ_RW-1:0] s_root;
	side6_t           side_a_q [SQRT_LAT];

	rsi_sqrt u_sqrt_disc (
		.clk  (clk),
		.x    (disc_s6),
		.root (s_root)
	);

	always_ff @(posedge clk) begin
		side_a_q[0] <= side_s6;
		for (int i = 1; i < SQRT_LAT; i++)
			side_a_q[i] <= side_a_q[i-1];
	end

	// ---------------- s7: root numerators ----------------
	side6_t            sa;
	side7_t            side_s7;
	logic [DIV_NW-1:0] num_n_s7, num_f_s7;
	logic [DIV_DW-1:0] a_s7;
	logic [64:0]       numf_c;

	assign sa = side_a_q[SQRT_LAT-1];

	always_comb begin
		if (sa.hpos)
			numf_c = {1'b0, s_root - sa.hmag};
		else
			numf_c = {1'b0, sa.hmag} + {1'b0, s_root};
	end

	always_ff @(posedge clk) begin
		side_s7.nohit <= sa.azero | sa.dneg;
		side_s7.hpos  <= sa.hpos;
		side_s7.vn    <= ~sa.hpos & (sa.hmag > s_root);
		side_s7.vf    <= ~sa.hpos | (s_root > sa.hmag);
		side_s7.o     <= sa.o;
		side_s7.d     <= sa.d;
		num_n_s7      <= DIV_NW'(sa.hmag - s_root) << FRAC_BITS;
		num_f_s7      <= DIV_NW'(numf_c) << FRAC_BITS;
		a_s7          <= sa.a;
	end

	// ---------------- root divisions ----------------
	logic [DIV_QW-1:0] tn_raw, tf_raw;
	side7_t            side_b_q [DIV_LAT];

	rsi_div u_div_near (
		.clk (clk),
		.num (num_n_s7),
		.den (a_s7),
		.quo (tn_raw)
	);

	rsi_div u_div_far (
		.clk (clk),
		.num (num_f_s7),
		.den (a_s7),
		.quo (tf_raw)
	);

	always_ff @(posedge clk) begin
		side_b_q[0] <= side_s7;
		for (int i = 1; i < DIV_LAT; i++)
			side_b_q[i] <= side_b_q[i-1];
	end

	// ---------------- s8: root choice ----------------
	side7_t            sb;
	logic [DIST_W-1:0] tn_c, tf_c, mind_c, t_c;
	logic              hit_c;
	logic              hit_s8;
	logic [DIST_W-1:0] t_s8;
	vec3_t             o_s8, d_s8;

	assign sb     = side_b_q[DIV_LAT-1];
	assign tn_c   = tn_raw[DIV_QW-1] ? T_MAX : tn_raw[DIST_W-1:0];
	assign tf_c   = tf_raw[DIV_QW-1] ? T_MAX : tf_raw[DIST_W-1:0];
	assign mind_c = DIST_W'(min_distance_q);

	always_comb begin
		hit_c = 1'b0;
		t_c   = tf_c;
		if (!sb.nohit) begin
			if (sb.vn && (tn_c > mind_c)) begin
				hit_c = 1'b1;
				t_c   = tn_c;
			end else if (sb.vf && (tf_c > mind_c)) begin
				hit_c = 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		hit_s8 <= hit_c;
		t_s8   <= t_c;
		o_s8   <= sb.o;
		d_s8   <= sb.d;
	end

	// ---------------- s9: t times direction ----------------
	logic               hit_s9;
	logic [DIST_W-1:0]  t_s9;
	vec3_t              o_s9;
	logic signed [63:0] td_s9 [3];

	always_ff @(posedge clk) begin
		hit_s9 <= hit_s8;
		t_s9   <= t_s8;
		o_s9   <= o_s8;
		for (int i = 0; i < 3; i++)
			td_s9[i] <= $signed({1'b0, t_s8}) * $signed(d_s8[i]);
	end

	// ---------------- s10: hit point ----------------
	logic               hit_s10;
	logic [DIST_W-1:0]  t_s10;
	vec3_t              p_s10;
	logic [63:0]        tdmag_c [3];
	logic signed [63:0] psum_c  [3];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			tdmag_c[i] = td_s9[i][63] ? 64'(-td_s9[i]) : 64'(td_s9[i]);
			// truncate toward zero, then restore the sign
			if (td_s9[i][63])
				psum_c[i] = 64'($signed(o_s9[i])) - $signed(tdmag_c[i] >> FRAC_BITS);
			else
				psum_c[i] = 64'($signed(o_s9[i])) + $signed(tdmag_c[i] >> FRAC_BITS);
		end
	end

	always_ff @(posedge clk) begin
		hit_s10 <= hit_s9;
		t_s10   <= t_s9;
		for (int i = 0; i < 3; i++)
			p_s10[i] <= sat32(psum_c[i]);
	end

	// ---------------- s11: squares of the point ----------------
	logic              hit_s11, szero_s11;
	logic [DIST_W-1:0] t_s11;
	vec3_t             p_s11;
	logic [63:0]       psq_s11 [3];

	always_ff @(posedge clk) begin
		hit_s11   <= hit_s10;
		t_s11     <= t_s10;
		p_s11     <= p_s10;
		szero_s11 <= p_s10 == '0;
		for (int i = 0; i < 3; i++)
			psq_s11[i] <= abs32(p_s10[i]) * abs32(p_s10[i]);
	end

	// ---------------- s12: length squared ----------------
	side12_t     side_s12;
	logic [63:0] sq_s12;

	always_ff @(posedge clk) begin
		side_s12.hit   <= hit_s11;
		side_s12.szero <= szero_s11;
		side_s12.t     <= t_s11;
		side_s12.p     <= p_s11;
		sq_s12         <= psq_s11[0] + psq_s11[1] + psq_s11[2];
	end

	// ---------------- length, scaled by 2^32 ----------------
	logic [SQ_RW-1:0] len_root;
	side12_t          side_c_q [SQRT_LAT];

	rsi_sqrt u_sqrt_len (
		.clk  (clk),
		.x    ({sq_s12, 64'd0}),
		.root (len_root)
	);

	always_ff @(posedge clk) begin
		side_c_q[0] <= side_s12;
		for (int i = 1; i < SQRT_LAT; i++)
			side_c_q[i] <= side_c_q[i-1];
	end

	// ---------------- s13: normal numerators ----------------
	side12_t           side_s13;
	logic [DIV_NW-1:0] nnum_s13 [3];
	logic [DIV_DW-1:0] len_s13;

	always_ff @(posedge clk) begin
		side_s13 <= side_c_q[SQRT_LAT-1];
		len_s13  <= len_root;
		for (int i = 0; i < 3; i++)
			nnum_s13[i] <= DIV_NW'(abs32(side_c_q[SQRT_LAT-1].p[i])) << NORM_SHIFT;
	end

	logic [DIV_QW-1:0] nq [3];
	side12_t           side_d_q [DIV_LAT];

	genvar g;
	for (g = 0; g < 3; g++) begin : g_norm
		rsi_div u_div_norm (
			.clk (clk),
			.num (nnum_s13[g]),
			.den (len_s13),
			.quo (nq[g])
		);
	end

	always_ff @(posedge clk) begin
		side_d_q[0] <= side_s13;
		for (int i = 1; i < DIV_LAT; i++)
			side_d_q[i] <= side_d_q[i-1];
	end

	// ---------------- s14: result registers ----------------
	side12_t           sd;
	logic              is_hit_s14;
	logic [DIST_W-1:0] dist_s14;
	vec3_t             p_s14, n_s14;
	logic [DW-1:0]     nmag_c [3];

	assign sd = side_d_q[DIV_LAT-1];

	always_comb begin
		for (int i = 0; i < 3; i++)
			nmag_c[i] = (nq[i] > NORM_ONE) ? NORM_ONE : nq[i];
	end

	always_ff @(posedge clk) begin
		is_hit_s14 <= sd.hit;
		dist_s14   <= sd.hit ? sd.t : T_MAX;
		for (int i = 0; i < 3; i++) begin
			p_s14[i] <= sd.hit ? sd.p[i] : '0;
			if (!sd.hit || sd.szero)
				n_s14[i] <= '0;
			else
				n_s14[i] <= sd.p[i][DW-1] ? DW'(-nmag_c[i]) : nmag_c[i];
		end
	end

	assign is_hit       = is_hit_s14;
	assign hit_distance = dist_s14;
	assign point_x      = p_s14[0];
	assign point_y      = p_s14[1];
	assign point_z      = p_s14[2];
	assign normal_x     = n_s14[0];
	assign normal_y     = n_s14[1];
	assign normal_z     = n_s14[2];

endmodule

/* rtl/rsi_sqrt.sv */
// ----------------------------------------------------------------------------
// rsi_sqrt
// pipelined integer square root, floor(sqrt(x)), one root bit per stage
// ----------------------------------------------------------------------------
module rsi_sqrt (
	input  logic                       clk,
	input  logic [rsi_pkg::SQ_XW-1:0]  x,
	output logic [rsi_pkg::SQ_RW-1:0]  root
);
	import rsi_pkg::*;

	localparam int REM_W = SQ_RW + 1;

	logic [REM_W-1:0] rem_s [SQ_RW];
	logic [SQ_RW-1:0] r_s   [SQ_RW];
	logic [SQ_XW-1:0] x_s   [SQ_RW];

	genvar k;
	for (k = 0; k < SQ_RW; k++) begin : g_step
		logic [REM_W-1:0]   rem_i;
		logic [SQ_RW-1:0]   r_i;
		logic [SQ_XW-1:0]   x_i;
		logic [REM_W+1:0]   cat;
		logic [REM_W+1:0]   trial;
		logic               ge;

		if (k == 0) begin : g_first
			assign rem_i = '0;
			assign r_i   = '0;
			assign x_i   = x;
		end else begin : g_next
			assign rem_i = rem_s[k-1];
			assign r_i   = r_s[k-1];
			assign x_i   = x_s[k-1];
		end

		// bring down the next two bits of the radicand
		assign cat   = {rem_i, x_i[SQ_XW-1:SQ_XW-2]};
		assign trial = {1'b0, r_i, 2'b01};
		assign ge    = cat >= trial;

		always_ff @(posedge clk) begin
			rem_s[k] <= ge ? REM_W'(cat - trial) : REM_W'(cat);
			r_s[k]   <= {r_i[SQ_RW-2:0], ge};
			x_s[k]   <= x_i << 2;
		end
	end

	assign root = r_s[SQ_RW-1];

endmodule

/* rtl/rsi_div.sv */
// ----------------------------------------------------------------------------
// rsi_div
// pipelined restoring divider, quotient saturates at all ones
// ----------------------------------------------------------------------------
module rsi_div (
	input  logic                        clk,
	input  logic [rsi_pkg::DIV_NW-1:0]  num,
	input  logic [rsi_pkg::DIV_DW-1:0]  den,
	output logic [rsi_pkg::DIV_QW-1:0]  quo
);
	import rsi_pkg::*;

	logic [DIV_NW-1:0] rem_s [DIV_QW];
	logic [DIV_DW-1:0] den_s [DIV_QW];
	logic [DIV_QW-1:0] q_s   [DIV_QW];
	logic              sat_s [DIV_QW];

	genvar j;
	for (j = 0; j < DIV_QW; j++) begin : g_step
		logic [DIV_NW-1:0] rem_i;
		logic [DIV_NW-1:0] dsh;
		logic [DIV_DW-1:0] den_i;
		logic [DIV_QW-1:0] q_i;
		logic              sat_i;
		logic              ge;

		if (j == 0) begin : g_first
			assign rem_i = num;
			assign den_i = den;
			assign q_i   = '0;
			// quotient would not fit
			assign sat_i = num >= {den, {DIV_QW{1'b0}}};
		end else begin : g_next
			assign rem_i = rem_s[j-1];
			assign den_i = den_s[j-1];
			assign q_i   = q_s[j-1];
			assign sat_i = sat_s[j-1];
		end

		assign dsh = DIV_NW'(den_i) << (DIV_QW - 1 - j);
		assign ge  = rem_i >= dsh;

		always_ff @(posedge clk) begin
			rem_s[j] <= ge ? rem_i - dsh : rem_i;
			den_s[j] <= den_i;
			q_s[j]   <= {q_i[DIV_QW-2:0], ge};
			sat_s[j] <= sat_i;
		end
	end

	assign quo = sat_s[DIV_QW-1] ? '1 : q_s[DIV_QW-1];

endmodule

/* rtl/rsi_checker.sv */
// ----------------------------------------------------------------------------
// rsi_checker
// port-level checks of the ray/sphere intersection, bound to the top level
// ----------------------------------------------------------------------------
module rsi_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       start,
	input logic                       busy,
	input logic                       done,
	input logic                       is_hit,
	input logic [rsi_pkg::DIST_W-1:0] hit_distance,
	input logic signed [31:0]         point_x,
	input logic signed [31:0]         point_y,
	input logic signed [31:0]         point_z,
	input logic signed [31:0]         normal_x,
	input logic signed [31:0]         normal_y,
	input logic signed [31:0]         normal_z
);
	import rsi_pkg::*;

	// every result beat comes from a ray taken a fixed time earlier
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, PIPE_LAT))
		else $error("result beat without matching ray");

	// a miss reports the maximum distance and zero point and normal
	a_miss: assert property (@(posedge clk) disable iff (!arst_n)
		done && !is_hit |-> hit_distance == T_MAX
			&& point_x == 0 && point_y == 0 && point_z == 0
			&& normal_x == 0 && normal_y == 0 && normal_z == 0)
		else $error("miss beat carries data");

	// a hit lies strictly beyond the minimum distance, so t is never zero
	a_hit_dist: assert property (@(posedge clk) disable iff (!arst_n)
		done && is_hit |-> hit_distance != 0)
		else $error("hit at zero distance");

	// normal components stay within unit range
	a_norm_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> normal_x <= 32'sd1073741824 && normal_x >= -32'sd1073741824
			&& normal_y <= 32'sd1073741824 && normal_y >= -32'sd1073741824
			&& normal_z <= 32'sd1073741824 && normal_z >= -32'sd1073741824)
		else $error("normal component out of range");

endmodule

bind ray_sphere_intersection rsi_checker u_rsi_checker (.*);

/* verif/tb_ray_sphere_intersection.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_ray_sphere_intersection
// drives rays through the sphere intersector and checks each result against
// a bit-exact quadratic solver held in the bench, over several radius and
// minimum-distance settings, with bursty start traffic
// ----------------------------------------------------------------------------
module tb_ray_sphere_intersection;
	import rsi_pkg::*;

	localparam int  LIMIT    = 400000;
	localparam int  MAX_SHOW = 10;

	typedef struct packed {
		logic [2:0][31:0] o;
		logic [2:0][31:0] d;
	} ray_t;

	typedef struct packed {
		logic              hit;
		logic [DIST_W-1:0] t_hit;
		logic [2:0][31:0]  p;
		logic [2:0][31:0]  n;
	} hit_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic wr_en = 1'b0;
	logic [IDX_W-1:0] wr_index = '0;
	logic [CFG_W-1:0] wr_data = '0;
	logic [2:0][31:0] drv_o = '0;
	logic [2:0][31:0] drv_d = '0;
	logic busy, done, is_hit;
	logic [DIST_W-1:0] hit_distance;
	logic signed [31:0] point_x, point_y, point_z, normal_x, normal_y, normal_z;

	ray_sphere_intersection u_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data),
		.origin_x(drv_o[0]), .origin_y(drv_o[1]), .origin_z(drv_o[2]),
		.direction_x(drv_d[0]), .direction_y(drv_d[1]), .direction_z(drv_d[2]),
		.done(done), .is_hit(is_hit), .hit_distance(hit_distance),
		.point_x(point_x), .point_y(point_y), .point_z(point_z),
		.normal_x(normal_x), .normal_y(normal_y), .normal_z(normal_z)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	logic [RAD_W-1:0]  radius_q = RAD_RST;
	logic [MIND_W-1:0] min_dist_q = MIND_RST;
	hit_t expected_hits[$];
	int mismatches = 0;
	int results_seen = 0;
	int hits_seen = 0;
	int rays_sent = 0;
	int burst_left = 0;
	int cycles = 0;

	// ---------------- solver ----------------
	function automatic longint unsigned mag64(longint v);
		return v < 0 ? longint'(-v) : v;
	endfunction

	function automatic logic [63:0] isqrt(logic [127:0] x);
		logic [63:0] r;
		logic [63:0] cand;
		r = '0;
		for (int b = 63; b >= 0; b--) begin
			cand = r | (64'd1 << b);
			if ({64'd0, cand} * {64'd0, cand} <= x) r = cand;
		end
		return r;
	endfunction

	function automatic logic [63:0] quot_cap(logic [127:0] x, logic [63:0] dv, logic [63:0] cap);
		logic [127:0] q;
		q = x / {64'd0, dv};
		return (q > {64'd0, cap}) ? cap : q[63:0];
	endfunction

	function automatic logic [31:0] clamp32(longint v);
		if (v > 64'sd2147483647) return 32'h7fff_ffff;
		if (v < -64'sd2147483648) return 32'h8000_0000;
		return v[31:0];
	endfunction

	function automatic hit_t trace_sphere(ray_t r);
		hit_t res;
		longint unsigned a, oo, hp, hm, hmag, cmag, r2, t, tq, sq, len, q, nv;
		longint pr, pv;
		logic [127:0] hh, ac, disc;
		logic [63:0] s;
		bit hpos, cneg, found;
		res = '0;
		res.t_hit = T_MAX;
		a = 0; oo = 0; hp = 0; hm = 0; sq = 0; t = 0;
		for (int i = 0; i < 3; i++) begin
			a += mag64(longint'($signed(r.d[i]))) * mag64(longint'($signed(r.d[i])));
			oo += mag64(longint'($signed(r.o[i]))) * mag64(longint'($signed(r.o[i])));
			pr = longint'($signed(r.d[i])) * longint'($signed(r.o[i]));
			if (pr >= 0) hp += pr; else hm += -pr;
		end
		if (a == 0) return res;
		hpos = hp > hm;
		hmag = (hp >= hm) ? hp - hm : hm - hp;
		r2 = longint'(radius_q) * longint'(radius_q);
		cneg = oo < r2;
		cmag = cneg ? r2 - oo : oo - r2;
		hh = {64'd0, hmag} * {64'd0, hmag};
		ac = {64'd0, a} * {64'd0, cmag};
		if (cneg) disc = hh + ac;
		else if (hh < ac) return res;
		else disc = hh - ac;
		s = isqrt(disc);
		found = 1'b0;
		if (!hpos) begin
			if (hmag > s) begin
				tq = quot_cap({64'd0, hmag - s} << FRAC_BITS, a, 64'(T_MAX));
				if (tq > min_dist_q) begin found = 1'b1; t = tq; end
			end
			if (!found) begin
				tq = quot_cap(({64'd0, hmag} + {64'd0, s}) << FRAC_BITS, a, 64'(T_MAX));
				if (tq > min_dist_q) begin found = 1'b1; t = tq; end
			end
		end else if (s > hmag) begin
			tq = quot_cap({64'd0, s - hmag} << FRAC_BITS, a, 64'(T_MAX));
			if (tq > min_dist_q) begin found = 1'b1; t = tq; end
		end
		if (!found) return res;
		res.hit = 1'b1;
		res.t_hit = t[DIST_W-1:0];
		for (int i = 0; i < 3; i++) begin
			pr = longint'(t) * longint'($signed(r.d[i]));
			q = mag64(pr) >> FRAC_BITS;
			pv = longint'($signed(r.o[i])) + ((pr < 0) ? -longint'(q) : longint'(q));
			res.p[i] = clamp32(pv);
			sq += mag64(longint'($signed(res.p[i]))) * mag64(longint'($signed(res.p[i])));
		end
		if (sq != 0) begin
			len = isqrt({sq, 64'd0});
			for (int i = 0; i < 3; i++) begin
				nv = quot_cap({64'd0, mag64(longint'($signed(res.p[i])))} << NORM_SHIFT,
					len, 64'(NORM_ONE));
				res.n[i] = $signed(res.p[i]) < 0 ? 32'(-nv) : nv[31:0];
			end
		end
		return res;
	endfunction

	// ---------------- result checking ----------------
	always @(posedge clk) begin
		hit_t want;
		hit_t got;
		if (arst_n && done) begin
			got.hit = is_hit;
			got.t_hit = hit_distance;
			got.p = {point_z, point_y, point_x};
			got.n = {normal_z, normal_y, normal_x};
			results_seen++;
			if (is_hit) hits_seen++;
			if (expected_hits.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_SHOW) $display("unexpected result beat at %0t", $time);
			end else begin
				want = expected_hits.pop_front();
				if (got != want) begin
					mismatches++;
					if (mismatches <= MAX_SHOW) begin
						$display("mismatch at %0t: hit %0b/%0b t %h/%h", $time,
							want.hit, got.hit, want.t_hit, got.t_hit);
						$display("  point exp %h act %h", want.p, got.p);
						$display("  normal exp %h act %h", want.n, got.n);
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("end of test: mismatches");
			$finish;
		end
	end

	// ---------------- stimulus helpers ----------------
	task automatic send_ray(ray_t r);
		int gap;
		start <= 1'b1;
		drv_o <= r.o;
		drv_d <= r.d;
		@(posedge clk);
		while (busy) @(posedge clk);
		expected_hits.push_back(trace_sphere(r));
		rays_sent++;
		if (burst_left > 0) burst_left--;
		if (burst_left == 0) begin
			// occasional long burst with no idling at all
			burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 80)
				: $urandom_range(1, 12);
			gap = $urandom_range(0, 6);
			if (gap > 0) begin
				start <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	task automatic drain;
		start <= 1'b0;
		while (expected_hits.size() != 0) @(posedge clk);
	endtask

	task automatic write_reg(reg_idx_t idx, logic [CFG_W-1:0] val);
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= val;
		@(posedge clk);
		wr_en <= 1'b0;
		if (idx == REG_RADIUS) radius_q = val[RAD_W-1:0];
		else min_dist_q = val[MIND_W-1:0];
		@(posedge clk);
	endtask

	function automatic ray_t mk_ray(longint ox, longint oy, longint oz,
		longint dx, longint dy, longint dz);
		ray_t r;
		r.o = {clamp32(oz), clamp32(oy), clamp32(ox)};
		r.d = {clamp32(dz), clamp32(dy), clamp32(dx)};
		return r;
	endfunction

	function automatic longint rand_span(longint span);
		return longint'($urandom_range(0, 32'(2 * span))) - span;
	endfunction

	function automatic ray_t random_ray();
		ray_t r;
		longint rr, span, tgt, ov[3], dv[3];
		int sh;
		int mode;
		mode = $urandom_range(0, 99);
		rr = (radius_q == 0) ? 65536 : longint'(radius_q);
		if (rr > 64'sd536870912) rr = 64'sd536870912;
		span = rr * 4;
		if (span > 64'sd1073741824) span = 64'sd1073741824;
		sh = $urandom_range(0, 8);
		if (mode < 15) begin
			r.o = {$urandom, $urandom, $urandom};
			r.d = {$urandom, $urandom, $urandom};
			return r;
		end
		for (int i = 0; i < 3; i++) begin
			if (mode < 30) begin
				// origin inside the sphere, any direction
				ov[i] = rand_span(rr / 2);
				dv[i] = rand_span(64'sd1 << $urandom_range(1, 24));
			end else begin
				// origin drawn over a wider span, aimed roughly at the centre
				ov[i] = rand_span(span);
				tgt = rand_span(rr / 2);
				dv[i] = (tgt - ov[i]) >>> sh;
			end
		end
		return mk_ray(ov[0], ov[1], ov[2], dv[0], dv[1], dv[2]);
	endfunction

	task automatic random_phase(int count);
		for (int k = 0; k < count; k++) begin
			send_ray(random_ray());
			if (k == count / 2 && $urandom_range(0, 1)) begin
				drain;
				@(posedge clk);
			end
		end
		drain;
	endtask

	// ---------------- tests ----------------
	localparam longint ONE = 65536;

	task automatic test_special_cases;
		send_ray(mk_ray(4 * ONE, 0, 0, 0, 0, 0));          // zero direction
		send_ray(mk_ray(4 * ONE, 0, 0, 0, ONE, 0));        // misses sideways
		send_ray(mk_ray(4 * ONE, 0, 0, ONE, 0, 0));        // sphere behind
		send_ray(mk_ray(-4 * ONE, 0, 0, ONE, 0, 0));       // front hit
		send_ray(mk_ray(0, 3 * ONE, -5 * ONE, 0, 0, 2 * ONE));
		send_ray(mk_ray(0, 0, 0, 0, 0, -ONE));             // inside, far root
		send_ray(mk_ray(-4 * ONE, ONE, 0, ONE, 0, 0));     // tangent
		send_ray(mk_ray(-32767 * ONE, 0, 0, 1, 0, 0));     // huge t saturates
		send_ray(mk_ray(-ONE - 40, 0, 0, ONE, 0, 0));      // near root under min distance
		send_ray(mk_ray(-64'sd2147483648, -64'sd2147483648, -64'sd2147483648,
			64'sd2147483647, 64'sd2147483647, 64'sd2147483647));
		send_ray(mk_ray(64'sd2147483647, 64'sd2147483647, 64'sd2147483647,
			-64'sd2147483648, -64'sd2147483648, -64'sd2147483648));
		send_ray(mk_ray(0, 0, 0, -64'sd2147483648, 0, 0));
		send_ray(mk_ray(-64'sd2147483648, 0, 0, 1, 0, 0));
		send_ray(mk_ray(0, 0, 64'sd2147483647, 0, 0, -1));
		drain;
	endtask

	task automatic test_zero_radius;
		write_reg(REG_RADIUS, '0);
		write_reg(REG_MIN_DIST, '0);
		send_ray(mk_ray(-ONE, 0, 0, ONE, 0, 0));           // hit lands on the centre
		send_ray(mk_ray(ONE, ONE, 0, 0, -ONE, 0));
		send_ray(mk_ray(0, 0, 0, ONE, 0, 0));
		drain;
	endtask

	task automatic test_max_settings;
		write_reg(REG_RADIUS, {CFG_W{1'b1}});
		write_reg(REG_MIN_DIST, 31'(16'hffff));
		send_ray(mk_ray(0, 0, 0, ONE, 0, 0));
		send_ray(mk_ray(0, 0, 0, 1, 1, 1));
		send_ray(mk_ray(-64'sd2147483648, 0, 0, 64'sd2147483647, 0, 0));
		send_ray(mk_ray(5, -7, 3, -64'sd2147483648, 64'sd2147483647, 1));
		drain;
	endtask

	task automatic test_random_sweep;
		write_reg(REG_RADIUS, 31'(ONE));
		write_reg(REG_MIN_DIST, 31'(66));
		random_phase(260);
		write_reg(REG_RADIUS, 31'(100 * ONE));
		write_reg(REG_MIN_DIST, '0);
		random_phase(260);
		write_reg(REG_RADIUS, 31'd3);
		write_reg(REG_MIN_DIST, 31'(16'hffff));
		random_phase(250);
		write_reg(REG_RADIUS, {CFG_W{1'b1}});
		write_reg(REG_MIN_DIST, 31'($urandom_range(0, 65535)));
		random_phase(250);
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_special_cases;
		test_zero_radius;
		test_max_settings;
		test_random_sweep;
		repeat (PIPE_LAT + 20) @(posedge clk);
		mismatches += expected_hits.size();
		$display("%0d rays over radius 0 to max and min distance 0 to max", rays_sent);
		$display("%0d results checked, %0d of them hits", results_seen, hits_seen);
		if (mismatches == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule
